// ----- src/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the program cache
// Geometry, request/result words, stored row layout, controller interface.
// ----------------------------------------------------------------------------
package spc_pkg;

	// NUM_SETS is taken to be a power of two; the set index is the low bits
	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 4;
	localparam int SET_W    = $clog2(NUM_SETS);
	localparam int WAY_W    = $clog2(NUM_WAYS);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_FILL   = 2'd1,
		OP_INVAL  = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	localparam logic [2:0] ST_MISS   = 3'd0;
	localparam logic [2:0] ST_MRU    = 3'd1;
	localparam logic [2:0] ST_TABLE  = 3'd2;
	localparam logic [2:0] ST_FILLED = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] program_id;
		logic [63:0] descriptor_key;
		logic [31:0] new_program;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] program_out;
		logic [1:0]  slot_used;
		logic        evicted;
	} resp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] key;
		logic [31:0] prog;
	} entry_t;

	// one memory word holds a whole set and its round-robin pointer
	typedef struct packed {
		logic [WAY_W-1:0]               ptr;
		entry_t [NUM_WAYS-1:0]          way;
	} row_t;

	typedef struct packed {
		logic accept;
		logic access;
		logic sweep;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} ctl_sts_t;

	function automatic logic [SET_W-1:0] set_of(input logic [63:0] key);
		logic [31:0] folded;
		folded = key[31:0] ^ key[63:32];
		return folded[SET_W-1:0];
	endfunction

endpackage

// ----- src/set_assoc_program_cache_unit.sv -----
// ----------------------------------------------------------------------------
// set_assoc_program_cache_unit: set-associative program cache
// Maps (program id, descriptor key) to a program handle, MRU register in front.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the word is taken at a
//   clock edge where start is high and busy is low.
//   Result channel: done is high for one cycle with result valid; the
//   receiver must take it then, there is no back pressure.
//   Lookup, fill and flush: the set row is read from memory at the accept
//   edge, checked and written back in the next cycle; done shows in the
//   cycle after that. No new word is taken until the row is written back;
//   busy holds it off during the registered read and the write-back.
//   Invalidate: sweeps all sets, one row written per cycle with the next
//   read overlapped; done shows in the cycle after the last row is written.
//   Reset: clears the MRU, the last pair and the per-set row valid flops at
//   once, so the store reads empty with no clearing pass; flush does the
//   same.
// ----------------------------------------------------------------------------
module set_assoc_program_cache_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  spc_pkg::req_t  request,
	output logic           done,
	output spc_pkg::resp_t result
);

	spc_pkg::ctl_cmd_t cmd;
	spc_pkg::ctl_sts_t sts;

	spc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	spc_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

// ----- src/spc_ctrl.sv -----
// ----------------------------------------------------------------------------
// spc_ctrl: sequencer of the program cache
// Accepts a word, then runs a single access or a sweep over all sets.
// ----------------------------------------------------------------------------
module spc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        operation,
	input  spc_pkg::ctl_sts_t sts,
	output logic              busy,
	output spc_pkg::ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_ACCESS = 3'b010,
		S_SWEEP  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == spc_pkg::OP_INVAL) state_d = S_SWEEP;
					else state_d = S_ACCESS;
				end
			end
			S_ACCESS: state_d = S_IDLE;
			S_SWEEP: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign cmd.accept = accept;
	assign cmd.access = (state_q == S_ACCESS);
	assign cmd.sweep  = (state_q == S_SWEEP);

endmodule

// ----- src/spc_datapath.sv -----
// ----------------------------------------------------------------------------
// spc_datapath: set store, MRU register and result register
// A memory row per set; a flop per row marks it written since flush or reset.
// ----------------------------------------------------------------------------
module spc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  spc_pkg::req_t     request,
	input  spc_pkg::ctl_cmd_t cmd,
	output spc_pkg::ctl_sts_t sts,
	output logic              done,
	output spc_pkg::resp_t    result
);

	localparam int SET_W = spc_pkg::SET_W;
	localparam int WAY_W = spc_pkg::WAY_W;
	localparam int NWAYS = spc_pkg::NUM_WAYS;
	localparam int NSETS = spc_pkg::NUM_SETS;

	spc_pkg::row_t mem [NSETS];
	spc_pkg::row_t rd_row_q;
	logic          rd_vld_q;
	logic [NSETS-1:0] row_vld_q;

	spc_pkg::req_t    req_q;
	logic [SET_W-1:0] wr_idx_q;
	logic [31:0]      mru_id_q;
	logic [63:0]      mru_key_q;
	logic [31:0]      mru_program_q;
	logic             mru_vld_q;
	logic [31:0]      last_id_q;
	logic [63:0]      last_key_q;
	spc_pkg::resp_t   resp_q;
	spc_pkg::resp_t   resp_d;
	logic             done_q;

	spc_pkg::row_t    cur, fill_row, sweep_row, wr_row;
	logic [SET_W-1:0] set_idx, rd_addr, wr_addr;
	logic             rd_en, wr_en;
	logic             is_lookup, is_fill, is_flush;
	logic             mru_hit, any_hit, any_empty, last_match, fill_ok;
	logic [WAY_W-1:0] hit_way, empty_way, pick, pick_next;
	logic [NWAYS-1:0] hit_w;
	spc_pkg::entry_t  new_entry;

	assign sts.sweep_last = (wr_idx_q == SET_W'(NSETS - 1));

	// rows not written since flush or reset read as empty
	assign cur = rd_vld_q ? rd_row_q : '0;

	assign set_idx   = spc_pkg::set_of(req_q.descriptor_key);
	assign is_lookup = (req_q.operation == spc_pkg::OP_LOOKUP);
	assign is_fill   = (req_q.operation == spc_pkg::OP_FILL);
	assign is_flush  = (req_q.operation == spc_pkg::OP_FLUSH);
	assign fill_ok   = is_fill && (req_q.program_id != 32'd0);

	assign mru_hit = mru_vld_q && (mru_id_q == req_q.program_id) &&
		(mru_key_q == req_q.descriptor_key);
	assign last_match = (last_id_q == req_q.program_id) &&
		(last_key_q == req_q.descriptor_key);

	always_comb begin
		hit_w     = '0;
		hit_way   = '0;
		empty_way = '0;
		for (int w = 0; w < NWAYS; w++) begin
			hit_w[w] = (cur.way[w].id != 32'd0) && (cur.way[w].id == req_q.program_id) &&
				(cur.way[w].key == req_q.descriptor_key);
		end
		// lowest way wins
		for (int w = NWAYS - 1; w >= 0; w--) begin
			if (hit_w[w]) hit_way = WAY_W'(w);
			if (cur.way[w].id == 32'd0) empty_way = WAY_W'(w);
		end
	end

	always_comb begin
		any_empty = 1'b0;
		for (int w = 0; w < NWAYS; w++) begin
			if (cur.way[w].id == 32'd0) any_empty = 1'b1;
		end
	end

	assign any_hit   = |hit_w;
	assign pick      = any_empty ? empty_way : cur.ptr;
	assign pick_next = (pick == WAY_W'(NWAYS - 1)) ? '0 : pick + WAY_W'(1);

	assign new_entry.id   = req_q.program_id;
	assign new_entry.key  = req_q.descriptor_key;
	assign new_entry.prog = req_q.new_program;

	always_comb begin
		fill_row           = cur;
		fill_row.way[pick] = new_entry;
		fill_row.ptr       = pick_next;
		sweep_row          = cur;
		for (int w = 0; w < NWAYS; w++) begin
			if (cur.way[w].id == req_q.program_id) sweep_row.way[w] = '0;
		end
	end

	assign wr_en   = (cmd.access && fill_ok) || cmd.sweep;
	assign wr_addr = cmd.sweep ? wr_idx_q : set_idx;
	assign wr_row  = cmd.sweep ? sweep_row : fill_row;

	// sweep reads the next set while writing back the current one
	assign rd_en = cmd.accept || (cmd.sweep && !sts.sweep_last);
	always_comb begin
		if (cmd.accept) begin
			if (request.operation == spc_pkg::OP_INVAL) rd_addr = '0;
			else rd_addr = spc_pkg::set_of(request.descriptor_key);
		end else begin
			rd_addr = wr_idx_q + SET_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
		if (rd_en) rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (rd_en) rd_vld_q <= row_vld_q[rd_addr];
			if (cmd.access && is_flush) row_vld_q <= '0;
			else if (wr_en) row_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q      <= '0;
			mru_id_q      <= '0;
			mru_key_q     <= '0;
			mru_program_q <= '0;
			mru_vld_q     <= 1'b0;
			last_id_q     <= '0;
			last_key_q    <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= (cmd.access || (cmd.sweep && sts.sweep_last));
			if (cmd.accept) wr_idx_q <= '0;
			else if (cmd.sweep) wr_idx_q <= wr_idx_q + SET_W'(1);

			if (cmd.access) begin
				if (is_lookup && !mru_hit) begin
					mru_vld_q <= any_hit && last_match;
					if (any_hit) begin
						if (last_match) begin
							mru_id_q      <= req_q.program_id;
							mru_key_q     <= req_q.descriptor_key;
							mru_program_q <= cur.way[hit_way].prog;
						end
						last_id_q  <= req_q.program_id;
						last_key_q <= req_q.descriptor_key;
					end
				end else if (fill_ok) begin
					last_id_q  <= req_q.program_id;
					last_key_q <= req_q.descriptor_key;
				end else if (is_flush) begin
					mru_id_q      <= '0;
					mru_key_q     <= '0;
					mru_program_q <= '0;
					mru_vld_q     <= 1'b0;
					last_id_q     <= '0;
					last_key_q    <= '0;
				end
			end else if (cmd.sweep && sts.sweep_last) begin
				if (mru_id_q == req_q.program_id) begin
					mru_id_q      <= '0;
					mru_key_q     <= '0;
					mru_program_q <= '0;
					mru_vld_q     <= 1'b0;
				end
				if (last_id_q == req_q.program_id) begin
					last_id_q  <= '0;
					last_key_q <= '0;
				end
			end
		end
	end

	always_comb begin
		resp_d = '0;
		if (cmd.sweep) begin
			resp_d.status = spc_pkg::ST_DONE;
		end else if (is_lookup) begin
			if (mru_hit) begin
				resp_d.status      = spc_pkg::ST_MRU;
				resp_d.program_out = mru_program_q;
			end else if (any_hit) begin
				resp_d.status      = spc_pkg::ST_TABLE;
				resp_d.program_out = cur.way[hit_way].prog;
				resp_d.slot_used   = 2'(hit_way);
			end
		end else if (is_fill) begin
			if (fill_ok) begin
				resp_d.status    = spc_pkg::ST_FILLED;
				resp_d.slot_used = 2'(pick);
				resp_d.evicted   = !any_empty;
			end
		end else begin
			resp_d.status = spc_pkg::ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access || (cmd.sweep && sts.sweep_last)) resp_q <= resp_d;
	end

	assign done   = done_q;
	assign result = resp_q;

endmodule

// ----- src/spc_checker.sv -----
// ----------------------------------------------------------------------------
// spc_checker: port-level checks of the program cache
// Watches the request/result handshake and result word consistency.
// ----------------------------------------------------------------------------
module spc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input spc_pkg::req_t  request,
	input logic           done,
	input spc_pkg::resp_t result
);

	// an accepted word holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// lookup, fill and flush finish in fixed time
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation != spc_pkg::OP_INVAL) |-> ##2 done)
		else $error("result missing two cycles after accept");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= spc_pkg::ST_DONE))
		else $error("status code out of range");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == spc_pkg::ST_MISS || result.status == spc_pkg::ST_DONE))
		|-> (result.program_out == 32'd0 && result.slot_used == 2'd0 && !result.evicted))
		else $error("miss or done word carries data");

endmodule

bind set_assoc_program_cache_unit spc_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the set-associative program cache
// A table of directed words, then random traffic over a small pool of
// id/key pairs packed into a few sets, so that MRU loads, round-robin
// evictions, invalidates and flushes all happen often. Every result word is
// checked against a typed step's word or this module's cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;

	typedef spc_pkg::req_t   req_t;
	typedef spc_pkg::resp_t  resp_t;
	typedef spc_pkg::entry_t entry_t;
	typedef spc_pkg::op_t    op_t;

	localparam int NUM_SETS = spc_pkg::NUM_SETS;
	localparam int NUM_WAYS = spc_pkg::NUM_WAYS;
	localparam int WAY_W    = spc_pkg::WAY_W;

	localparam op_t OP_LOOKUP = spc_pkg::OP_LOOKUP;
	localparam op_t OP_FILL   = spc_pkg::OP_FILL;
	localparam op_t OP_INVAL  = spc_pkg::OP_INVAL;
	localparam op_t OP_FLUSH  = spc_pkg::OP_FLUSH;

	localparam logic [2:0] ST_MISS   = spc_pkg::ST_MISS;
	localparam logic [2:0] ST_MRU    = spc_pkg::ST_MRU;
	localparam logic [2:0] ST_TABLE  = spc_pkg::ST_TABLE;
	localparam logic [2:0] ST_FILLED = spc_pkg::ST_FILLED;
	localparam logic [2:0] ST_DONE   = spc_pkg::ST_DONE;

	localparam int N_STEPS  = 25;
	localparam int PHASE_N  = 384;
	localparam int POOL_N   = 16;
	localparam int MAX_GAP  = 40;

	typedef struct packed {
		req_t  req;
		logic  typed;
		resp_t want;
	} step_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  request;
	logic  done;
	resp_t result;

	set_assoc_program_cache_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	entry_t           ways [NUM_SETS][NUM_WAYS];
	logic [WAY_W-1:0] rr_ptr [NUM_SETS];
	entry_t           mru_entry;
	logic             mru_ok;
	logic [31:0]      last_id;
	logic [63:0]      last_key;

	resp_t pending_results [$];
	resp_t head;
	int    errors = 0;

	// random pair pool
	logic [31:0] pool_id [POOL_N];
	logic [63:0] pool_key [POOL_N];

	// most keys sit in set 0: their two halves fold to zero in the low bits
	step_t steps [0:N_STEPS-1] = '{
		'{req_t'{OP_LOOKUP, 32'd5, 64'h1234, 32'd0}, 1'b1, resp_t'{ST_MISS, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_FILL, 32'd0, 64'h77, 32'h55}, 1'b1, resp_t'{ST_MISS, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_FILL, 32'd1, 64'd0, 32'hFFFF_FFFF}, 1'b1,
			resp_t'{ST_FILLED, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd1, 64'd0, 32'd0}, 1'b1,
			resp_t'{ST_TABLE, 32'hFFFF_FFFF, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd1, 64'd0, 32'd0}, 1'b1,
			resp_t'{ST_MRU, 32'hFFFF_FFFF, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd0, 64'd0, 32'd0}, 1'b1, resp_t'{ST_MISS, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd1, 64'd0, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_FILL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_FILL, 32'd2, 64'h0000_000A_0000_000A, 32'h22}, 1'b0, resp_t'('0)},
		'{req_t'{OP_FILL, 32'd3, 64'h1234_5678_1234_5678, 32'h33}, 1'b0, resp_t'('0)},
		'{req_t'{OP_FILL, 32'd4, 64'hDEAD_BEEF_DEAD_BEEF, 32'h44}, 1'b0, resp_t'('0)},
		'{req_t'{OP_LOOKUP, 32'd1, 64'd0, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_LOOKUP, 32'd2, 64'h0000_000A_0000_000A, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_LOOKUP, 32'd2, 64'h0000_000A_0000_000A, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_LOOKUP, 32'd2, 64'h0000_000A_0000_000A, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_INVAL, 32'hFFFF_FFFF, 64'd0, 32'd0}, 1'b1,
			resp_t'{ST_DONE, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_INVAL, 32'd0, 64'd0, 32'd0}, 1'b1, resp_t'{ST_DONE, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_INVAL, 32'd2, 64'd0, 32'd0}, 1'b1, resp_t'{ST_DONE, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd2, 64'h0000_000A_0000_000A, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_FLUSH, 32'd0, 64'd0, 32'd0}, 1'b1, resp_t'{ST_DONE, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'd3, 64'h1234_5678_1234_5678, 32'd0}, 1'b1,
			resp_t'{ST_MISS, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_FILL, 32'h8000_0001, 64'h8000_0000_0000_003F, 32'hA5A5_5A5A}, 1'b1,
			resp_t'{ST_FILLED, 32'd0, 2'd0, 1'b0}},
		'{req_t'{OP_LOOKUP, 32'h8000_0001, 64'h8000_0000_0000_003F, 32'd0}, 1'b0, resp_t'('0)},
		'{req_t'{OP_LOOKUP, 32'h8000_0001, 64'h8000_0000_0000_003F, 32'd0}, 1'b0, resp_t'('0)}
	};

	function automatic void clear_cache();
		for (int s = 0; s < NUM_SETS; s++) begin
			rr_ptr[s] = '0;
			for (int w = 0; w < NUM_WAYS; w++)
				ways[s][w] = '0;
		end
		mru_entry = '0;
		mru_ok    = 1'b0;
		last_id   = '0;
		last_key  = '0;
	endfunction

	function automatic resp_t cache_access(input req_t r);
		resp_t       res;
		logic [31:0] fold;
		int          s;
		int          pick;
		logic        hit;
		res  = '0;
		hit  = 1'b0;
		fold = r.descriptor_key[31:0] ^ r.descriptor_key[63:32];
		s    = int'(fold % NUM_SETS);
		case (op_t'(r.operation))
			OP_LOOKUP: begin
				if (mru_ok && mru_entry.id == r.program_id &&
				    mru_entry.key == r.descriptor_key) begin
					res.status      = ST_MRU;
					res.program_out = mru_entry.prog;
				end else begin
					mru_ok = 1'b0;
					for (int w = 0; w < NUM_WAYS; w++) begin
						if (!hit && ways[s][w].id != 0 && ways[s][w].id == r.program_id &&
						    ways[s][w].key == r.descriptor_key) begin
							hit             = 1'b1;
							res.status      = ST_TABLE;
							res.program_out = ways[s][w].prog;
							res.slot_used   = 2'(w);
							// a hit on the pair last filled or last hit promotes it
							if (last_id == r.program_id && last_key == r.descriptor_key) begin
								mru_entry = ways[s][w];
								mru_ok    = 1'b1;
							end
							last_id  = r.program_id;
							last_key = r.descriptor_key;
						end
					end
				end
			end
			OP_FILL: begin
				if (r.program_id != 0) begin
					pick = NUM_WAYS;
					for (int w = NUM_WAYS - 1; w >= 0; w--)
						if (ways[s][w].id == 0)
							pick = w;
					if (pick == NUM_WAYS) begin
						pick        = int'(rr_ptr[s]);
						res.evicted = 1'b1;
					end
					ways[s][pick] = '{id: r.program_id, key: r.descriptor_key,
						prog: r.new_program};
					rr_ptr[s]     = WAY_W'((pick + 1) % NUM_WAYS);
					last_id       = r.program_id;
					last_key      = r.descriptor_key;
					res.status    = ST_FILLED;
					res.slot_used = 2'(pick);
				end
			end
			OP_INVAL: begin
				if (mru_entry.id == r.program_id) begin
					mru_entry = '0;
					mru_ok    = 1'b0;
				end
				if (last_id == r.program_id) begin
					last_id  = '0;
					last_key = '0;
				end
				for (int i = 0; i < NUM_SETS; i++)
					for (int w = 0; w < NUM_WAYS; w++)
						if (ways[i][w].id == r.program_id)
							ways[i][w] = '0;
				res.status = ST_DONE;
			end
			default: begin
				clear_cache();
				res.status = ST_DONE;
			end
		endcase
		return res;
	endfunction

	// called at a clock edge; returns at the edge where the word is taken
	task automatic issue(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic int idle_gap(input int pct);
		int g;
		g = 0;
		while (g < MAX_GAP && $urandom_range(0, 99) < pct)
			g++;
		return g;
	endfunction

	function automatic void new_pair(input int k);
		logic [63:0] key;
		key = {$urandom, $urandom};
		// most keys crowd into sets 0..3 to force evictions
		if ($urandom_range(0, 4) != 0)
			key[5:0] = key[37:32] ^ 6'($urandom_range(0, 3));
		pool_key[k] = key;
		pool_id[k]  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 5));
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: status %0d program %h slot %0d evicted %b",
						result.status, result.program_out, result.slot_used, result.evicted);
			end else begin
				head = pending_results.pop_front();
				if (result.status !== head.status || result.program_out !== head.program_out ||
				    result.slot_used !== head.slot_used || result.evicted !== head.evicted) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d/%h/%0d/%b, got %0d/%h/%0d/%b",
							head.status, head.program_out, head.slot_used, head.evicted,
							result.status, result.program_out, result.slot_used, result.evicted);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		req_t  r;
		resp_t p;
		int    pct;
		int    n;
		int    k;
		int    reps;
		int    kind;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		clear_cache();
		for (int i = 0; i < POOL_N; i++)
			new_pair(i);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			issue(steps[i].req, 0);
			p = cache_access(steps[i].req);
			pending_results.push_back(steps[i].typed ? steps[i].want : p);
		end
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 20 : (phase == 1) ? 79 : 0;
			n = 0;
			while (n < PHASE_N) begin
				k    = $urandom_range(0, POOL_N - 1);
				kind = $urandom_range(0, 99);
				reps = 1;
				r.program_id     = pool_id[k];
				r.descriptor_key = pool_key[k];
				r.new_program    = $urandom;
				if (kind < 6) begin
					// noise: any op, any fields
					r.operation      = 2'($urandom_range(0, 3));
					r.program_id     = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
					r.descriptor_key = {$urandom, $urandom};
				end else if (kind < 10) begin
					r.operation = OP_INVAL;
				end else if (kind < 11) begin
					r.operation = OP_FLUSH;
				end else if (kind < 40) begin
					r.operation = OP_FILL;
					if ($urandom_range(0, 9) == 0)
						new_pair(k);
					r.program_id     = pool_id[k];
					r.descriptor_key = pool_key[k];
				end else begin
					r.operation = OP_LOOKUP;
					reps = $urandom_range(1, 3);
				end
				for (int j = 0; j < reps; j++) begin
					issue(r, idle_gap(pct));
					pending_results.push_back(cache_access(r));
					n++;
				end
				if ($urandom_range(0, 199) == 0)
					drain();
			end
			drain();
		end

		repeat (2 * NUM_SETS) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- set_assoc_program_cache_unit.f -----
src/spc_pkg.sv
src/spc_ctrl.sv
src/spc_datapath.sv
src/set_assoc_program_cache_unit.sv
src/spc_checker.sv
dv/tb_top.sv
